// ===== rtl/gapg_pkg.sv =====
`default_nettype none
package gapg_pkg;

  localparam int OP_W  = 1;
  localparam int ROW_W = 3;
  localparam int COL_W = 4;
  localparam int LEN_W = 7;

  localparam int RI_W  = 4;
  localparam int CI_W  = 5;
  localparam int CNT_W = 10;
  localparam int G_W   = 10;

  localparam int FRAC_BITS = 16;
  localparam int D2_W      = 11;
  localparam int H_W       = 22;
  localparam int RAD_W     = 44;
  localparam int EST_W     = G_W + FRAC_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_BUILD = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_ROT,
    LOP_DEL,
    LOP_APPEND,
    LOP_UPDATE
  } lop_t;

  typedef enum logic [1:0] {
    PH_RESET,
    PH_TRY,
    PH_RETRY
  } ph_t;

  typedef enum logic [4:0] {
    ST_INIT_D2,
    ST_INIT_WAIT,
    ST_IDLE,
    ST_DECIDE,
    ST_S_CLR,
    ST_S_SEED,
    ST_NB,
    ST_NB_CHK,
    ST_NB_END,
    ST_SCAN,
    ST_DEL,
    ST_POP_RD,
    ST_POP_WR,
    ST_S_DONE,
    ST_UNBLK,
    ST_P_CLR,
    ST_P_RD,
    ST_P_STEP,
    ST_FIN_RD,
    ST_FIN,
    ST_RESP
  } st_t;

  typedef struct packed {
    logic [RI_W-1:0]  row;
    logic [CI_W-1:0]  col;
    logic [EST_W-1:0] est;
  } ent_t;

  typedef struct packed {
    lop_t             op;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] pos;
    ent_t             ent;
  } lctl_t;

  typedef struct packed {
    logic            open;
    logic            closed;
    dir_t            parent;
    logic [G_W-1:0]  cost;
  } node_t;

  typedef struct packed {
    logic            valid;
    logic [RI_W-1:0] row;
    logic [CI_W-1:0] col;
  } nb_t;

endpackage
`default_nettype wire

// ===== rtl/gapg_if.sv =====
`default_nettype none
interface gapg_req_if;
  import gapg_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_col;
  modport source(output valid, opcode, cell_row, cell_col, input ready);
  modport sink(input valid, opcode, cell_row, cell_col, output ready);
endinterface

interface gapg_rsp_if;
  import gapg_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [LEN_W-1:0] path_length;
  logic             cell_blocked;
  logic             cell_on_path;
  modport source(output valid, accepted, path_length, cell_blocked, cell_on_path, input ready);
  modport sink(input valid, accepted, path_length, cell_blocked, cell_on_path, output ready);
endinterface
`default_nettype wire

// ===== rtl/gapg_ram.sv =====
`default_nettype none
module gapg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/gapg_isqrt.sv =====
`default_nettype none
module gapg_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gapg_pkg::D2_W-1:0] d2,
  output logic                      done,
  output logic [gapg_pkg::H_W-1:0]  root
);
  import gapg_pkg::*;

  localparam int N_W = $clog2(H_W);

  logic [RAD_W-1:0] v;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bit_q;
  logic [RAD_W-1:0] trial;
  logic [N_W-1:0]   n;
  logic             run;

  assign trial = res + bit_q;
  assign root  = res[H_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v     <= RAD_W'({d2, {(2*FRAC_BITS){1'b0}}});
        res   <= '0;
        bit_q <= RAD_W'(1) << (2 * (H_W - 1));
        n     <= N_W'(H_W - 1);
        run   <= 1'b1;
      end else if (run) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bit_q;
        end else begin
          res <= res >> 1;
        end
        bit_q <= bit_q >> 2;
        if (n == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          n <= n - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gapg_open_cell.sv =====
`default_nettype none
module gapg_open_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  gapg_pkg::lctl_t ctl,
  input  gapg_pkg::ent_t  right,
  input  gapg_pkg::ent_t  head,
  output gapg_pkg::ent_t  q
);
  import gapg_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  always_ff @(posedge clk) begin
    case (ctl.op)
      LOP_ROT: begin
        q <= (MY_NEXT == ctl.cnt) ? head : right;
      end
      LOP_DEL: begin
        if (MY_IDX >= ctl.pos) begin
          q <= right;
        end
      end
      LOP_APPEND: begin
        if (MY_IDX == ctl.cnt) begin
          q <= ctl.ent;
        end
      end
      LOP_UPDATE: begin
        if (MY_IDX < ctl.cnt && q.row == ctl.ent.row && q.col == ctl.ent.col) begin
          q.est <= ctl.ent.est;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/grid_astar_path_guard.sv =====
// channel | dir | payload                                          | accepted when
// req     | in  | opcode, cell_row, cell_col                       | valid & ready
// rsp     | out | accepted, path_length, cell_blocked, cell_on_path | valid & ready
//
// one item at a time; a query reads the cell's blocked and path bits (none when out of range),
// a build request runs one or two searches, each a clear sweep of all rows*cols cells
// plus, per expanded cell, a check of its neighbors, the pop and one open-list rotation
// per open entry
// after reset an init pass computes the heuristic table, one square root per cell,
// then one search; req.ready stays low until it is done
// rsp is a register: a new item is taken while a result waits; work stalls at the end
`default_nettype none
module grid_astar_path_guard #(
  parameter int GRID_ROWS = 7,
  parameter int GRID_COLS = 16
) (
  input  logic       clk,
  input  logic       rst,
  gapg_req_if.sink   req,
  gapg_rsp_if.source rsp
);
  import gapg_pkg::*;

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int NODE_W = $bits(node_t);

  localparam logic [RI_W-1:0]   MID_ROW   = RI_W'(GRID_ROWS / 2);
  localparam logic [RI_W-1:0]   LAST_ROW  = RI_W'(GRID_ROWS - 1);
  localparam logic [CI_W-1:0]   LAST_COL  = CI_W'(GRID_COLS - 1);
  localparam logic [CNT_W-1:0]  CELLS_C   = CNT_W'(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  function automatic logic [ADDR_W-1:0] addr_of(logic [RI_W-1:0] r, logic [CI_W-1:0] c);
    return ADDR_W'(int'(r) * GRID_COLS + int'(c));
  endfunction

  function automatic nb_t step_to(logic [RI_W-1:0] r, logic [CI_W-1:0] c, dir_t d);
    nb_t n;
    n.row   = r;
    n.col   = c;
    n.valid = 1'b0;
    case (d)
      DIR_UP: begin
        n.valid = (r != '0);
        n.row   = r - 1'b1;
      end
      DIR_DOWN: begin
        n.valid = (int'(r) + 1 < GRID_ROWS);
        n.row   = r + 1'b1;
      end
      DIR_LEFT: begin
        n.valid = (c != '0);
        n.col   = c - 1'b1;
      end
      DIR_RIGHT: begin
        n.valid = (int'(c) + 1 < GRID_COLS);
        n.col   = c + 1'b1;
      end
      default: begin
        n.valid = 1'b0;
      end
    endcase
    return n;
  endfunction

  localparam logic [ADDR_W-1:0] START_ADDR = ADDR_W'(int'(MID_ROW) * GRID_COLS);
  localparam logic [ADDR_W-1:0] END_ADDR   = ADDR_W'(int'(MID_ROW) * GRID_COLS + GRID_COLS - 1);

  st_t  state, state_next;
  ph_t  phase;
  logic found;

  logic [RI_W-1:0]   init_row, cur_row, nb_row, best_row, t_row;
  logic [CI_W-1:0]   init_col, cur_col, nb_col, best_col, t_col;
  logic [ADDR_W-1:0] sw_addr, it_addr;
  logic [G_W-1:0]    cur_g;
  dir_t              dir;
  op_t               it_op;
  logic [CNT_W-1:0]  cnt, k, best_pos, path_count;
  logic [EST_W-1:0]  best_est;
  logic              res_acc, res_blk, res_onp;
  logic              rsp_valid, out_acc, out_blk, out_onp;
  logic [LEN_W-1:0]  out_len;

  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              blk_we, blk_wd, blk_rd;
  logic              path_we, path_wd, path_rd;
  logic              node_we, h_we;
  node_t             node_wd, node_rd;
  logic [NODE_W-1:0] node_rd_raw;
  logic [H_W-1:0]    h_rd, isq_root;
  logic              isq_start, isq_done;
  logic [D2_W-1:0]   init_d2;

  lctl_t             lctl;
  ent_t              chain_q [CELLS];

  nb_t               nb_cur, nb_par;
  logic [G_W-1:0]    ng;
  logic [EST_W-1:0]  est_new;
  logic              in_range;
  logic              do_accept;
  logic              rsp_load;

  assign node_rd = node_t'(node_rd_raw);

  assign nb_cur  = step_to(cur_row, cur_col, dir);
  assign nb_par  = step_to(t_row, t_col, dir_t'({node_rd.parent[1], ~node_rd.parent[0]}));
  assign ng      = cur_g + 1'b1;
  assign est_new = (EST_W'(ng) << FRAC_BITS) + EST_W'(h_rd);

  assign in_range  = (int'(req.cell_row) < GRID_ROWS) && (int'(req.cell_col) < GRID_COLS);
  assign req.ready = (state == ST_IDLE);
  assign do_accept = req.valid && req.ready;
  assign rsp_load  = (state == ST_RESP) && (!rsp_valid || rsp.ready);

  assign init_d2 = D2_W'((int'(init_row) - int'(MID_ROW)) * (int'(init_row) - int'(MID_ROW))
                         + int'(init_col) * int'(init_col));

  gapg_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (isq_start),
    .d2    (init_d2),
    .done  (isq_done),
    .root  (isq_root)
  );

  gapg_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk_ram (
    .clk(clk), .we(blk_we), .waddr(wr_addr), .wdata(blk_wd), .raddr(rd_addr), .rdata(blk_rd)
  );

  gapg_ram #(.WIDTH(1), .DEPTH(CELLS)) u_path_ram (
    .clk(clk), .we(path_we), .waddr(wr_addr), .wdata(path_wd), .raddr(rd_addr),
    .rdata(path_rd)
  );

  gapg_ram #(.WIDTH(NODE_W), .DEPTH(CELLS)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(wr_addr), .wdata(NODE_W'(node_wd)), .raddr(rd_addr),
    .rdata(node_rd_raw)
  );

  gapg_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_h_ram (
    .clk(clk), .we(h_we), .waddr(wr_addr), .wdata(isq_root), .raddr(rd_addr), .rdata(h_rd)
  );

  // open list: row of cells, rotated through the head for the min scan
  for (genvar i = 0; i < CELLS; i++) begin : gen_cell
    ent_t right;
    if (i == CELLS - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = chain_q[i+1];
    end
    gapg_open_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctl   (lctl),
      .right (right),
      .head  (chain_q[0]),
      .q     (chain_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_D2;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    isq_start  = 1'b0;
    rd_addr    = it_addr;
    wr_addr    = sw_addr;
    blk_we     = 1'b0;
    blk_wd     = 1'b0;
    path_we    = 1'b0;
    path_wd    = 1'b0;
    node_we    = 1'b0;
    node_wd    = '0;
    h_we       = 1'b0;
    lctl.op    = LOP_NONE;
    lctl.cnt   = cnt;
    lctl.pos   = best_pos;
    lctl.ent   = '{row: nb_row, col: nb_col, est: est_new};
    case (state)
      ST_INIT_D2: begin
        isq_start  = 1'b1;
        state_next = ST_INIT_WAIT;
      end
      ST_INIT_WAIT: begin
        wr_addr = addr_of(init_row, init_col);
        if (isq_done) begin
          h_we    = 1'b1;
          blk_we  = 1'b1;
          path_we = 1'b1;
          if (init_row == LAST_ROW && init_col == LAST_COL) begin
            state_next = ST_S_CLR;
          end else begin
            state_next = ST_INIT_D2;
          end
        end
      end
      ST_IDLE: begin
        rd_addr = addr_of(RI_W'(req.cell_row), CI_W'(req.cell_col));
        if (do_accept) begin
          state_next = in_range ? ST_DECIDE : ST_RESP;
        end
      end
      ST_DECIDE: begin
        wr_addr = it_addr;
        if (it_op == OP_BUILD && !blk_rd && it_addr != START_ADDR && it_addr != END_ADDR) begin
          blk_we     = 1'b1;
          blk_wd     = 1'b1;
          state_next = ST_S_CLR;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_S_CLR: begin
        node_we = 1'b1;
        if (sw_addr == LAST_ADDR) begin
          state_next = ST_S_SEED;
        end
      end
      ST_S_SEED: begin
        wr_addr        = END_ADDR;
        node_we        = 1'b1;
        node_wd.closed = 1'b1;
        state_next     = ST_NB;
      end
      ST_NB: begin
        rd_addr = addr_of(nb_cur.row, nb_cur.col);
        if (nb_cur.valid) begin
          state_next = ST_NB_CHK;
        end else if (dir == DIR_RIGHT) begin
          state_next = ST_NB_END;
        end
      end
      ST_NB_CHK: begin
        wr_addr = addr_of(nb_row, nb_col);
        node_wd = '{open: 1'b1, closed: 1'b0, parent: dir, cost: ng};
        if (!blk_rd && !node_rd.closed) begin
          if (!node_rd.open) begin
            node_we = 1'b1;
            if (cnt != CELLS_C) begin
              lctl.op = LOP_APPEND;
            end
          end else if (ng < node_rd.cost) begin
            node_we = 1'b1;
            lctl.op = LOP_UPDATE;
          end
        end
        state_next = (dir == DIR_RIGHT) ? ST_NB_END : ST_NB;
      end
      ST_NB_END: begin
        state_next = (cnt == '0) ? ST_S_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        lctl.op = LOP_ROT;
        if (k == cnt - 1'b1) begin
          state_next = ST_DEL;
        end
      end
      ST_DEL: begin
        lctl.op    = LOP_DEL;
        state_next = ST_POP_RD;
      end
      ST_POP_RD: begin
        rd_addr    = addr_of(cur_row, cur_col);
        state_next = ST_POP_WR;
      end
      ST_POP_WR: begin
        wr_addr        = addr_of(cur_row, cur_col);
        node_we        = 1'b1;
        node_wd        = node_rd;
        node_wd.open   = 1'b0;
        node_wd.closed = 1'b1;
        state_next     = (cur_row == MID_ROW && cur_col == '0) ? ST_S_DONE : ST_NB;
      end
      ST_S_DONE: begin
        state_next = (phase == PH_TRY && !found) ? ST_UNBLK : ST_P_CLR;
      end
      ST_UNBLK: begin
        wr_addr    = it_addr;
        blk_we     = 1'b1;
        state_next = ST_S_CLR;
      end
      ST_P_CLR: begin
        path_we = 1'b1;
        if (sw_addr == LAST_ADDR) begin
          if (found) begin
            state_next = ST_P_RD;
          end else begin
            state_next = (phase == PH_RESET) ? ST_IDLE : ST_FIN_RD;
          end
        end
      end
      ST_P_RD: begin
        rd_addr    = addr_of(t_row, t_col);
        state_next = ST_P_STEP;
      end
      ST_P_STEP: begin
        wr_addr = addr_of(nb_par.row, nb_par.col);
        if (!nb_par.valid || (nb_par.row == MID_ROW && nb_par.col == LAST_COL)
            || path_count == CELLS_C) begin
          state_next = (phase == PH_RESET) ? ST_IDLE : ST_FIN_RD;
        end else begin
          path_we    = 1'b1;
          path_wd    = 1'b1;
          state_next = ST_P_RD;
        end
      end
      ST_FIN_RD: begin
        rd_addr    = it_addr;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RESET;
      found      <= 1'b0;
      init_row   <= '0;
      init_col   <= '0;
      sw_addr    <= '0;
      cnt        <= '0;
      path_count <= '0;
    end else begin
      case (state)
        ST_INIT_WAIT: begin
          if (isq_done) begin
            if (init_col == LAST_COL) begin
              init_col <= '0;
              init_row <= init_row + 1'b1;
            end else begin
              init_col <= init_col + 1'b1;
            end
          end
        end
        ST_IDLE: begin
          if (do_accept) begin
            it_op   <= op_t'(req.opcode);
            it_addr <= addr_of(RI_W'(req.cell_row), CI_W'(req.cell_col));
            res_acc <= 1'b0;
            res_blk <= 1'b0;
            res_onp <= 1'b0;
          end
        end
        ST_DECIDE: begin
          res_blk <= blk_rd;
          res_onp <= path_rd;
          phase   <= PH_TRY;
          sw_addr <= '0;
        end
        ST_S_CLR: begin
          cnt     <= '0;
          found   <= 1'b0;
          sw_addr <= (sw_addr == LAST_ADDR) ? '0 : sw_addr + 1'b1;
        end
        ST_S_SEED: begin
          cur_row <= MID_ROW;
          cur_col <= LAST_COL;
          cur_g   <= '0;
          dir     <= DIR_UP;
        end
        ST_NB: begin
          nb_row <= nb_cur.row;
          nb_col <= nb_cur.col;
          if (!nb_cur.valid && dir != DIR_RIGHT) begin
            dir <= dir_t'(dir + 2'd1);
          end
        end
        ST_NB_CHK: begin
          if (!blk_rd && !node_rd.closed && !node_rd.open && cnt != CELLS_C) begin
            cnt <= cnt + 1'b1;
          end
          if (dir != DIR_RIGHT) begin
            dir <= dir_t'(dir + 2'd1);
          end
        end
        ST_NB_END: begin
          k <= '0;
        end
        ST_SCAN: begin
          if (k == '0 || chain_q[0].est < best_est) begin
            best_est <= chain_q[0].est;
            best_pos <= k;
            best_row <= chain_q[0].row;
            best_col <= chain_q[0].col;
          end
          k <= k + 1'b1;
        end
        ST_DEL: begin
          cur_row <= best_row;
          cur_col <= best_col;
          cnt     <= cnt - 1'b1;
        end
        ST_POP_WR: begin
          cur_g <= node_rd.cost;
          dir   <= DIR_UP;
          if (cur_row == MID_ROW && cur_col == '0) begin
            found <= 1'b1;
          end
        end
        ST_S_DONE: begin
          sw_addr <= '0;
          if (phase == PH_TRY && found) begin
            res_acc <= 1'b1;
          end
        end
        ST_UNBLK: begin
          phase <= PH_RETRY;
        end
        ST_P_CLR: begin
          path_count <= '0;
          sw_addr    <= (sw_addr == LAST_ADDR) ? '0 : sw_addr + 1'b1;
          t_row      <= MID_ROW;
          t_col      <= '0;
        end
        ST_P_STEP: begin
          if (nb_par.valid && !(nb_par.row == MID_ROW && nb_par.col == LAST_COL)
              && path_count != CELLS_C) begin
            path_count <= path_count + 1'b1;
            t_row      <= nb_par.row;
            t_col      <= nb_par.col;
          end
        end
        ST_FIN: begin
          res_blk <= blk_rd;
          res_onp <= path_rd;
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_acc <= res_acc;
      out_len <= LEN_W'(path_count);
      out_blk <= res_blk;
      out_onp <= res_onp;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.accepted     = out_acc;
  assign rsp.path_length  = out_len;
  assign rsp.cell_blocked = out_blk;
  assign rsp.cell_on_path = out_onp;

endmodule
`default_nettype wire

// ===== sim/grid_astar_path_guard_test.sv =====
module grid_astar_path_guard_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gapg_pkg::*;

  localparam int ROWS = 7;
  localparam int COLS = 16;
  localparam int CELLS = ROWS * COLS;
  localparam int MID = ROWS / 2;
  localparam int START_TILE = MID * COLS;
  localparam int END_TILE = MID * COLS + COLS - 1;
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic             accepted;
    logic [LEN_W-1:0] path_length;
    logic             cell_blocked;
    logic             cell_on_path;
  } mark_t;

  class path_scoreboard;
    bit          blk[CELLS];
    bit          pmark[CELLS];
    dir_t        pdir[CELLS];
    int          cost[CELLS];
    longint      est[CELLS];
    bit          opn[CELLS];
    bit          cls[CELLS];
    int          olist[CELLS];
    int          ocnt;
    int          plen;
    mark_t       pending[$];
    int          errors;
    int          builds_kept;
    int          builds_refused;
    int          queries;

    function new();
      trace_path(find_path());
    endfunction

    function int neighbor(int tile, dir_t d);
      int r, c;
      r = tile / COLS;
      c = tile % COLS;
      case (d)
        DIR_UP:    r = r - 1;
        DIR_DOWN:  r = r + 1;
        DIR_LEFT:  c = c - 1;
        default:   c = c + 1;
      endcase
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return -1;
      return r * COLS + c;
    endfunction

    function longint dist_to_start(int tile);
      bit [63:0] v, res, b;
      int r, c;
      r = tile / COLS - MID;
      c = tile % COLS;
      v = 64'(r * r + c * c) << 32;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function bit find_path();
      int cur, n, ng, best;
      cur = END_TILE;
      for (int i = 0; i < CELLS; i++) begin
        opn[i] = 0;
        cls[i] = 0;
        cost[i] = 0;
      end
      ocnt = 0;
      cls[cur] = 1;
      forever begin
        for (int d = 0; d < 4; d++) begin
          n = neighbor(cur, dir_t'(d));
          if (n < 0) continue;
          if (blk[n] || cls[n]) continue;
          ng = cost[cur] + 1;
          if (!opn[n]) begin
            pdir[n] = dir_t'(d);
            cost[n] = ng;
            est[n] = (longint'(ng) << FRAC_BITS) + dist_to_start(n);
            if (ocnt < CELLS) begin
              olist[ocnt] = n;
              ocnt++;
            end
            opn[n] = 1;
          end else if (ng < cost[n]) begin
            pdir[n] = dir_t'(d);
            cost[n] = ng;
            est[n] = (longint'(ng) << FRAC_BITS) + dist_to_start(n);
          end
        end
        if (ocnt == 0) return 0;
        best = 0;
        for (int k = 1; k < ocnt; k++)
          if (est[olist[k]] < est[olist[best]]) best = k;
        cur = olist[best];
        for (int k = best; k < ocnt - 1; k++) olist[k] = olist[k + 1];
        ocnt--;
        opn[cur] = 0;
        cls[cur] = 1;
        if (cur == START_TILE) return 1;
      end
    endfunction

    function void trace_path(bit found);
      int p, guard;
      for (int i = 0; i < CELLS; i++) pmark[i] = 0;
      plen = 0;
      guard = 0;
      if (!found) return;
      // step back against the move that entered each cell
      p = neighbor(START_TILE, dir_t'(pdir[START_TILE] ^ 2'd1));
      while (p >= 0 && p != END_TILE && guard < CELLS) begin
        pmark[p] = 1;
        plen++;
        guard++;
        p = neighbor(p, dir_t'(pdir[p] ^ 2'd1));
      end
    endfunction

    function void note(op_t op, int row, int col);
      mark_t m;
      int tile;
      bit found;
      m = '0;
      if (row < ROWS && col < COLS) begin
        tile = row * COLS + col;
        if (op == OP_BUILD && !blk[tile] && tile != END_TILE && tile != START_TILE) begin
          blk[tile] = 1;
          found = find_path();
          if (found) begin
            m.accepted = 1;
          end else begin
            blk[tile] = 0;
            found = find_path();
          end
          trace_path(found);
        end
        m.cell_blocked = blk[tile];
        m.cell_on_path = pmark[tile];
      end
      m.path_length = plen[LEN_W-1:0];
      if (op == OP_QUERY) queries++;
      else if (m.accepted) builds_kept++;
      else builds_refused++;
      pending = {pending, m};
    endfunction

    function void check(mark_t got);
      mark_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted exp %0d got %0d", $realtime, want.accepted, got.accepted);
        errors++;
      end
      if (got.path_length !== want.path_length) begin
        $display("%0t: path_length exp %0d got %0d", $realtime,
                 want.path_length, got.path_length);
        errors++;
      end
      if (got.cell_blocked !== want.cell_blocked) begin
        $display("%0t: cell_blocked exp %0d got %0d", $realtime,
                 want.cell_blocked, got.cell_blocked);
        errors++;
      end
      if (got.cell_on_path !== want.cell_on_path) begin
        $display("%0t: cell_on_path exp %0d got %0d", $realtime,
                 want.cell_on_path, got.cell_on_path);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   beats_out;
  path_scoreboard sb;

  gapg_req_if req();
  gapg_rsp_if rsp();

  grid_astar_path_guard DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(op_t op, int row, int col);
    int gap;
    gap = $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      req.valid = 0;
      repeat (gap) @(negedge clk);
    end
    req.valid = 1;
    req.opcode = op;
    req.cell_row = row[ROW_W-1:0];
    req.cell_col = col[COL_W-1:0];
    do @(posedge clk); while (!req.ready);
    sb.note(op, row, col);
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) send(OP_BUILD, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
    else if (pick < 90) send(OP_QUERY, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
    else send(op_t'($urandom_range(0, 1)), 7, $urandom_range(0, 15));
  endtask

  initial begin
    int gap;
    rsp.ready = 0;
    beats_out = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 4);
      if (beats_out == 30) begin
        // long hold so the block backs up
        rsp.ready = 0;
        repeat (40000) @(negedge clk);
      end else if (gap > 0) begin
        rsp.ready = 0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready = 1;
      do @(posedge clk); while (!rsp.valid);
      sb.check({rsp.accepted, rsp.path_length, rsp.cell_blocked, rsp.cell_on_path});
      beats_out++;
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    rst = 1;
    req.valid = 0;
    req.opcode = OP_BUILD;
    req.cell_row = '0;
    req.cell_col = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: corners, start/end tiles, out of range, wall until refused
    send(OP_QUERY, 0, 0);
    send(OP_QUERY, MID, 0);
    send(OP_QUERY, MID, COLS - 1);
    send(OP_BUILD, MID, COLS - 1);
    send(OP_BUILD, MID, 0);
    send(OP_BUILD, 7, 15);
    send(OP_QUERY, 7, 0);
    send(OP_BUILD, MID, 1);
    send(OP_BUILD, MID, 1);
    send(OP_QUERY, 6, 15);
    for (int r = 0; r < ROWS - 1; r++) send(OP_BUILD, r, 5);
    send(OP_BUILD, ROWS - 1, 5);
    send(OP_QUERY, ROWS - 1, 5);
    send(OP_BUILD, 0, 10);
    send(OP_BUILD, 6, 10);

    for (int i = 0; i < 100; i++) begin
      if (i == 40) begin
        @(negedge clk);
        req.valid = 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_random();
    end
    @(negedge clk);
    req.valid = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d kept builds, %0d refused or out-of-range builds, %0d queries",
             sb.builds_kept, sb.builds_refused, sb.queries);
    $display("final path length %0d, %0d result beats", sb.plen, beats_out);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== grid_astar_path_guard.f =====
rtl/gapg_pkg.sv
rtl/gapg_if.sv
rtl/gapg_ram.sv
rtl/gapg_isqrt.sv
rtl/gapg_open_cell.sv
rtl/grid_astar_path_guard.sv
sim/grid_astar_path_guard_test.sv
